FILE: design/rrs_pkg.sv
`timescale 1ns / 1ps
// rrs_pkg: shared codes, field widths and the store entry type for the
// rank roulette selector. No dependencies.
package rrs_pkg;

  localparam int FIT_W  = 32;
  localparam int FRAC_W = 16;
  localparam int ID_W   = 6;
  localparam int RANK_W = 7;
  localparam int KIND_W = 2;
  localparam int STAT_W = 2;

  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SELECT = 2'd2;

  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

  // One store entry: insertion number and fitness.
  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic signed [FIT_W-1:0] fit;
  } entry_t;

endpackage

FILE: design/rrs_rank_scan.sv
`timescale 1ns / 1ps
// rrs_rank_scan: finds the first rank k with k(k+1)*2^15 >= r*n(n+1)/2.
// Depends on rrs_pkg.
module rrs_rank_scan import rrs_pkg::*; #(
  parameter int CW = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [CW-1:0]     count,
  input  logic [FRAC_W-1:0] frac,
  output logic              done,
  output logic [CW-1:0]     rank
);

  localparam int PW = 2 * CW + 1;
  localparam int TW = FRAC_W + PW - 1;

  localparam logic [1:0] SC_IDLE = 2'd0;
  localparam logic [1:0] SC_MUL  = 2'd1;
  localparam logic [1:0] SC_TGT  = 2'd2;
  localparam logic [1:0] SC_SCAN = 2'd3;

  logic [1:0]        state;
  logic [CW-1:0]     n_q;
  logic [FRAC_W-1:0] r_q;
  logic [PW-1:0]     prod;
  logic [TW-1:0]     target;
  logic [CW-1:0]     k;
  logic [PW-1:0]     lhs;   // k(k+1), stepped by 2(k+1)
  logic              hit;

  assign hit  = ({lhs, {(FRAC_W-1){1'b0}}} >= target) || (k == n_q);
  assign done = (state == SC_SCAN) && hit;
  assign rank = k;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SC_IDLE;
    end else begin
      case (state)
        SC_IDLE: begin
          if (start) begin
            n_q   <= count;
            r_q   <= frac;
            state <= SC_MUL;
          end
        end
        SC_MUL: begin
          prod  <= PW'(n_q) * (PW'(n_q) + PW'(1));
          state <= SC_TGT;
        end
        SC_TGT: begin
          target <= TW'(r_q) * TW'(prod >> 1);
          k      <= CW'(1);
          lhs    <= PW'(2);
          state  <= SC_SCAN;
        end
        SC_SCAN: begin
          if (hit) begin
            state <= SC_IDLE;
          end else begin
            k   <= k + CW'(1);
            lhs <= lhs + ((PW'(k) + PW'(1)) << 1);
          end
        end
        default: state <= SC_IDLE;
      endcase
    end
  end

  a_rank_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == SC_SCAN) |-> (k != '0 && k <= n_q))
    else $error("rank scan ran outside 1..n");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == SC_IDLE))
    else $error("rank scan started while busy");
  a_done_nonzero: assert property (@(posedge clk) disable iff (rst)
    done |=> (state == SC_IDLE))
    else $error("rank scan did not return to idle");

endmodule

FILE: design/rank_roulette_selector_unit.sv
`timescale 1ns / 1ps
// Rank roulette selector: keeps up to MAX_POP fitness values sorted ascending
// (stable for ties) in one single-port-write, registered-read memory, and
// draws an entry with linear rank weights. One item is in work at a time.
// Clear, no-op, dropped add, empty select and an add into an empty store go
// straight from execution to the result. Any other add shifts each stored
// entry larger than the new one up by one place (one entry moved per cycle
// through the memory) and then writes the new one; a select waits on the
// scan unit (one rank tested per cycle) and then reads the chosen entry.
// Depends on rrs_pkg and rrs_rank_scan.
module rank_roulette_selector_unit import rrs_pkg::*; #(
  parameter int MAX_POP = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [KIND_W-1:0]       kind,
  input  logic signed [FIT_W-1:0] fitness,
  input  logic [FRAC_W-1:0]       random_fraction,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [STAT_W-1:0]       status,
  output logic [ID_W-1:0]         selected_index,
  output logic signed [FIT_W-1:0] selected_fitness,
  output logic [RANK_W-1:0]       selected_rank
);

  localparam int AW = $clog2(MAX_POP);
  localparam int CW = $clog2(MAX_POP + 1);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_EXEC     = 3'd1;
  localparam logic [2:0] ST_INS_CMP  = 3'd2;
  localparam logic [2:0] ST_INS_PUT  = 3'd3;
  localparam logic [2:0] ST_SEL_WAIT = 3'd4;
  localparam logic [2:0] ST_SEL_RD   = 3'd5;
  localparam logic [2:0] ST_DONE     = 3'd6;

  logic [2:0]              state;
  logic [KIND_W-1:0]       kind_q;
  logic signed [FIT_W-1:0] fit_q;
  logic [FRAC_W-1:0]       frac_q;
  logic [CW-1:0]           count;
  logic [CW-1:0]           pos;
  logic [CW-1:0]           pos_m1;
  logic [CW-1:0]           pos_m2;

  logic [STAT_W-1:0]       res_status;
  logic [ID_W-1:0]         res_id;
  logic signed [FIT_W-1:0] res_fit;
  logic [RANK_W-1:0]       res_rank;

  entry_t mem [MAX_POP];
  entry_t rd_data;
  entry_t wr_data;
  entry_t new_entry;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          we;
  logic          larger;

  logic          scan_start;
  logic          scan_done;
  logic [CW-1:0] scan_rank;
  logic [CW-1:0] rank_m1;

  assign in_stall  = (state != ST_IDLE);
  assign pos_m1    = pos - CW'(1);
  assign pos_m2    = pos - CW'(2);
  assign rank_m1   = scan_rank - CW'(1);
  assign larger    = $signed(rd_data.fit) > fit_q;
  assign new_entry = '{id: ID_W'(count), fit: fit_q};
  assign scan_start = (state == ST_EXEC) && (kind_q == KIND_SELECT) && (count != '0);

  rrs_rank_scan #(.CW(CW)) u_scan (
    .clk   (clk),
    .rst   (rst),
    .start (scan_start),
    .count (count),
    .frac  (frac_q),
    .done  (scan_done),
    .rank  (scan_rank)
  );

  // Memory controls. The read of pos-2 and the write of pos never collide,
  // so no forwarding is needed while shifting.
  always_comb begin
    rd_addr = pos_m1[AW-1:0];
    wr_addr = pos[AW-1:0];
    wr_data = new_entry;
    we      = 1'b0;
    case (state)
      ST_EXEC: begin
        rd_addr = AW'(count - CW'(1));
        if (kind_q == KIND_ADD && count == '0) begin
          wr_addr = '0;
          we      = 1'b1;
        end
      end
      ST_INS_CMP: begin
        rd_addr = pos_m2[AW-1:0];
        we      = 1'b1;
        if (larger) begin
          wr_data = rd_data;
        end
      end
      ST_INS_PUT: begin
        we = 1'b1;
      end
      ST_SEL_WAIT: begin
        rd_addr = rank_m1[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            kind_q <= kind;
            fit_q  <= fitness;
            frac_q <= random_fraction;
            state  <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          res_status <= STATUS_OK;
          res_id     <= '0;
          res_fit    <= '0;
          res_rank   <= '0;
          pos        <= count;
          state      <= ST_DONE;
          case (kind_q)
            KIND_CLEAR: count <= '0;
            KIND_ADD: begin
              if (count >= CW'(MAX_POP)) begin
                res_status <= STATUS_FULL;
              end else if (count == '0) begin
                count <= CW'(1);
              end else begin
                state <= ST_INS_CMP;
              end
            end
            KIND_SELECT: begin
              if (count == '0) begin
                res_status <= STATUS_EMPTY;
              end else begin
                state <= ST_SEL_WAIT;
              end
            end
            default: begin
            end
          endcase
        end
        ST_INS_CMP: begin
          // rd_data holds entry pos-1
          if (larger) begin
            pos <= pos_m1;
            if (pos_m1 == '0) begin
              state <= ST_INS_PUT;
            end
          end else begin
            count <= count + CW'(1);
            state <= ST_DONE;
          end
        end
        ST_INS_PUT: begin
          count <= count + CW'(1);
          state <= ST_DONE;
        end
        ST_SEL_WAIT: begin
          if (scan_done) begin
            res_rank <= RANK_W'(scan_rank);
            state    <= ST_SEL_RD;
          end
        end
        ST_SEL_RD: begin
          res_id  <= rd_data.id;
          res_fit <= rd_data.fit;
          state   <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            status           <= res_status;
            selected_index   <= res_id;
            selected_fitness <= res_fit;
            selected_rank    <= res_rank;
            out_valid        <= 1'b1;
            state            <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_POP))
    else $error("population count above capacity");
  a_shift_pos: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INS_CMP) |-> (pos != '0 && pos <= count))
    else $error("insert shift position out of range");
  a_scan_done_wait: assert property (@(posedge clk) disable iff (rst)
    scan_done |-> (state == ST_SEL_WAIT))
    else $error("rank scan finished outside a select");
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_DONE))
    else $error("result loaded outside the done state");

endmodule

FILE: tb/tb_rank_roulette_selector_unit.sv
`timescale 1ns / 1ps
// Testbench for rank_roulette_selector_unit: directed and random clear/add/select
// traffic, checked against an in-bench sorted-population model. Depends on rrs_pkg.
module tb_rank_roulette_selector_unit;
  import rrs_pkg::*;

  localparam int POP_MAX = 64;
  localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 100;

  typedef struct {
    logic [STAT_W-1:0]       status;
    logic [ID_W-1:0]         index;
    logic signed [FIT_W-1:0] fit;
    logic [RANK_W-1:0]       rank;
  } pick_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [KIND_W-1:0]       kind = KIND_NOP;
  logic signed [FIT_W-1:0] fitness = '0;
  logic [FRAC_W-1:0]       random_fraction = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [STAT_W-1:0]       status;
  logic [ID_W-1:0]         selected_index;
  logic signed [FIT_W-1:0] selected_fitness;
  logic [RANK_W-1:0]       selected_rank;

  rank_roulette_selector_unit #(.MAX_POP(POP_MAX)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .fitness(fitness), .random_fraction(random_fraction),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .selected_index(selected_index),
    .selected_fitness(selected_fitness), .selected_rank(selected_rank)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Population model: ascending fitness, ties in insertion order.
  logic signed [FIT_W-1:0] pool_fit [POP_MAX];
  logic [ID_W-1:0]         pool_id  [POP_MAX];
  int                      pool_count = 0;

  pick_t expected_picks [$];
  int    errors = 0;
  int    transfers_sent = 0;
  int    results_checked = 0;
  int    selects_seen = 0;
  int    full_drops = 0;
  int    empty_selects = 0;
  int    in_gap_pct = 0;
  int    out_stall_pct = 0;
  int    cycle_count = 0;
  int    stall_hold = 0;

  function automatic pick_t rank_select_predict(logic [KIND_W-1:0] k,
                                                logic signed [FIT_W-1:0] f,
                                                logic [FRAC_W-1:0] r);
    pick_t p;
    int pos;
    int j;
    longint unsigned total;
    longint unsigned target;
    p.status = STATUS_OK;
    p.index  = '0;
    p.fit    = '0;
    p.rank   = '0;
    case (k)
      KIND_CLEAR: begin
        pool_count = 0;
      end
      KIND_ADD: begin
        if (pool_count >= POP_MAX) begin
          p.status = STATUS_FULL;
        end else begin
          pos = pool_count;
          while (pos > 0 && pool_fit[pos-1] > f) begin
            pool_fit[pos] = pool_fit[pos-1];
            pool_id[pos]  = pool_id[pos-1];
            pos--;
          end
          pool_fit[pos] = f;
          pool_id[pos]  = pool_count[ID_W-1:0];
          pool_count++;
        end
      end
      KIND_SELECT: begin
        if (pool_count == 0) begin
          p.status = STATUS_EMPTY;
        end else begin
          total  = longint'(pool_count) * longint'(pool_count + 1) / 2;
          target = longint'(r) * total;
          j = 1;
          // rank n always passes since r < 65536
          while (longint'(j) * longint'(j + 1) * 32768 < target) j++;
          p.index = pool_id[j-1];
          p.fit   = pool_fit[j-1];
          p.rank  = j[RANK_W-1:0];
        end
      end
      default: begin
      end
    endcase
    return p;
  endfunction

  // Mostly short idle runs, now and then a long one.
  function automatic int pick_len();
    if ($urandom_range(1, 10) == 1) return $urandom_range(10, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic signed [FIT_W-1:0] pick_fitness();
    case ($urandom_range(0, 9))
      0, 1, 2: return FIT_W'($signed($urandom_range(0, 4)) - 2) <<< 16;
      3: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sh0000_0000;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [FRAC_W-1:0] pick_fraction();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hffff;
      default: return FRAC_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // One input transfer; the expectation is formed at the accepting edge.
  task automatic send_item(logic [KIND_W-1:0] k, logic signed [FIT_W-1:0] f,
                           logic [FRAC_W-1:0] r);
    int gap;
    gap = (in_gap_pct > 0 && $urandom_range(1, 100) <= in_gap_pct) ? pick_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    kind            <= k;
    fitness         <= f;
    random_fraction <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_picks.push_back(rank_select_predict(k, f, r));
    transfers_sent++;
  endtask

  task automatic test_directed();
    in_gap_pct    = 0;
    out_stall_pct = 0;
    send_item(KIND_SELECT, 0, 16'd0);          // select on empty population
    send_item(KIND_CLEAR, 0, 16'd0);
    send_item(KIND_NOP, 32'sh7fff_ffff, 16'hffff);
    send_item(KIND_ADD, 32'sh7fff_ffff, 16'd0);
    send_item(KIND_SELECT, 0, 16'hffff);      // single entry
    send_item(KIND_ADD, 32'sh8000_0000, 16'd0);
    send_item(KIND_ADD, 32'sh0000_0000, 16'd0);
    send_item(KIND_ADD, -32'sd1, 16'd0);
    send_item(KIND_ADD, 32'sh0000_0000, 16'd0); // tie with earlier zero
    send_item(KIND_ADD, 32'sh0001_0000, 16'd0);
    send_item(KIND_ADD, 32'sh0000_0000, 16'd0);
    send_item(KIND_SELECT, 0, 16'd0);
    send_item(KIND_SELECT, 0, 16'hffff);
    send_item(KIND_SELECT, 0, 16'h8000);
    send_item(KIND_SELECT, -32'sd1, 16'h5555);
    send_item(KIND_NOP, 32'sh8000_0000, 16'h0000);
    send_item(KIND_SELECT, 0, 16'haaaa);
    send_item(KIND_CLEAR, -32'sd1, 16'hffff);
    send_item(KIND_SELECT, 0, 16'h1234);      // empty after clear
    send_item(KIND_ADD, 32'sh0000_0000, 16'hffff);
    send_item(KIND_SELECT, 0, 16'h0001);
  endtask

  // Fill to capacity, then push adds into a full store.
  task automatic test_full_store();
    int i;
    in_gap_pct    = 0;
    out_stall_pct = 0;
    send_item(KIND_CLEAR, 0, 16'd0);
    for (i = 0; i < POP_MAX; i++) send_item(KIND_ADD, pick_fitness(), pick_fraction());
    for (i = 0; i < 3; i++) send_item(KIND_ADD, pick_fitness(), pick_fraction());
    send_item(KIND_SELECT, 0, 16'd0);
    send_item(KIND_SELECT, 0, 16'hffff);
    in_gap_pct    = 30;
    out_stall_pct = 30;
    for (i = 0; i < 12; i++) send_item(KIND_SELECT, pick_fitness(), pick_fraction());
    send_item(KIND_NOP, pick_fitness(), pick_fraction());
    send_item(KIND_ADD, pick_fitness(), pick_fraction());
  endtask

  // Mostly clear/add/select sequences with random content, some noise.
  task automatic test_random_traffic(int target_items);
    int adds;
    int sels;
    int i;
    while (transfers_sent < target_items) begin
      case ($urandom_range(0, 5))
        0: begin
          in_gap_pct = 0;
          out_stall_pct = 0;
        end
        1: begin
          in_gap_pct = 60;
          out_stall_pct = 60;
        end
        default: begin
          in_gap_pct = $urandom_range(0, 40);
          out_stall_pct = $urandom_range(0, 40);
        end
      endcase
      if ($urandom_range(1, 100) <= 85) begin
        if ($urandom_range(0, 3) != 0) send_item(KIND_CLEAR, $urandom, FRAC_W'($urandom));
        adds = ($urandom_range(1, 10) == 1) ? $urandom_range(40, 68) : $urandom_range(1, 12);
        for (i = 0; i < adds; i++) begin
          send_item(KIND_ADD, pick_fitness(), FRAC_W'($urandom));
          if ($urandom_range(0, 7) == 0) send_item(KIND_SELECT, $urandom, pick_fraction());
        end
        sels = $urandom_range(1, 6);
        for (i = 0; i < sels; i++) send_item(KIND_SELECT, $urandom, pick_fraction());
        if ($urandom_range(0, 4) == 0) send_item(KIND_NOP, $urandom, FRAC_W'($urandom));
      end else begin
        for (i = 0; i < 4; i++)
          send_item(KIND_W'($urandom_range(0, 3)), pick_fitness(), pick_fraction());
      end
    end
  endtask

  always @(posedge clk) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else if (out_stall_pct > 0 && $urandom_range(1, 100) <= out_stall_pct) begin
      out_stall  <= 1'b1;
      stall_hold <= pick_len();
    end else begin
      out_stall  <= 1'b0;
      stall_hold <= $urandom_range(0, 4);
    end
  end

  // Result checker: every output transfer against the oldest expectation.
  always @(posedge clk) begin
    pick_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_picks.size() == 0) begin
        $error("unexpected result: status %0d index %0d fitness %0d rank %0d",
               status, selected_index, selected_fitness, selected_rank);
        errors++;
      end else begin
        want = expected_picks.pop_front();
        results_checked++;
        if (want.status == STATUS_FULL) full_drops++;
        if (want.status == STATUS_EMPTY) empty_selects++;
        if (want.rank != 0) selects_seen++;
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          errors++;
        end
        if (selected_index !== want.index) begin
          $error("selected_index: expected %0d, actual %0d", want.index, selected_index);
          errors++;
        end
        if (selected_fitness !== want.fit) begin
          $error("selected_fitness: expected %0d, actual %0d", want.fit, selected_fitness);
          errors++;
        end
        if (selected_rank !== want.rank) begin
          $error("selected_rank: expected %0d, actual %0d", want.rank, selected_rank);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending",
               cycle_count, expected_picks.size());
      $display("rank_roulette_selector_unit verification failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_store();
    test_random_traffic(1200);
    in_valid <= 1'b0;
    while (expected_picks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d transfers in, %0d results checked: %0d ranked picks, %0d full-store drops,",
             transfers_sent, results_checked, selects_seen, full_drops);
    $display("%0d empty selects, %0d mismatches", empty_selects, errors);
    if (errors == 0 && expected_picks.size() == 0) begin
      $display("rank_roulette_selector_unit verification clean");
    end else begin
      $display("rank_roulette_selector_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/rrs_pkg.sv
design/rrs_rank_scan.sv
design/rank_roulette_selector_unit.sv
tb/tb_rank_roulette_selector_unit.sv
